>>> rtl/plac_pkg.sv
// Shared constants, register codes and unit request types for the PID length controller.
package plac_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int INTEGRAL_WIDTH = 48;

   // error magnitude is 33 bits; quotients carry FRAC_BITS more
   localparam int DIV_BITS     = 33 + FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

   localparam int MUL_A_BITS     = 33;
   localparam int DIGIT_BITS     = 17;
   localparam int DIGITS         = 3;
   localparam int DIGIT_SEL_BITS = $clog2(DIGITS);
   localparam int MUL_B_BITS     = DIGIT_BITS * DIGITS;
   localparam int MUL_ACC_BITS   = MUL_A_BITS + MUL_B_BITS;
   localparam int TERM_LIMIT_BIT = 61;
   localparam int TERM_BITS      = 64;

   localparam logic [16:0] ACT_ONE = 17'h10000;
   localparam logic [31:0] NOMINAL_RESET = 32'h0001_0000;

   localparam logic [1:0] CSR_GAIN_P         = 2'd0;
   localparam logic [1:0] CSR_GAIN_I         = 2'd1;
   localparam logic [1:0] CSR_GAIN_D         = 2'd2;
   localparam logic [1:0] CSR_NOMINAL_LENGTH = 2'd3;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [31:0]         divisor;
   } plac_div_req_type;

   typedef struct packed {
      logic                  start;
      logic [MUL_A_BITS-1:0] a;
      logic [MUL_B_BITS-1:0] b;
      logic                  neg;
   } plac_mul_req_type;

endpackage

>>> rtl/plac_div.sv
// Restoring divider: one quotient bit per cycle, shared by position and derivative.
module plac_div import plac_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  plac_div_req_type      req,
   output logic                  done,
   output logic [DIV_BITS-1:0]   quotient
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [31:0]             rem_ff, rem_in;
   logic [31:0]             divisor_ff, divisor_in;
   logic [DIV_BITS-1:0]     dq_ff, dq_in;

   logic [32:0] rem_shift;
   logic        fits;

   always_comb begin
      rem_shift  = {rem_ff, dq_ff[DIV_BITS-1]};
      fits       = rem_shift >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      dq_in      = dq_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_BITS'(DIV_BITS);
         rem_in     = '0;
         divisor_in = req.divisor;
         dq_in      = req.dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so 32 bits hold it
         rem_in = fits ? 32'(rem_shift - {1'b0, divisor_ff}) : rem_shift[31:0];
         dq_in  = {dq_ff[DIV_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      dq_ff      <= dq_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

>>> rtl/plac_mul.sv
// Digit-serial magnitude multiplier with fraction shift, saturation and sign.
module plac_mul import plac_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  plac_mul_req_type      req,
   output logic                  done,
   output logic [TERM_BITS-1:0]  term
);

   localparam int SHIFTED_BITS = MUL_ACC_BITS - FRAC_BITS;
   localparam int PP_BITS      = MUL_A_BITS + DIGIT_BITS;

   logic                      busy_ff, busy_in;
   logic                      acc_phase_ff, acc_phase_in;
   logic                      fin_ff, fin_in;
   logic                      done_ff;
   logic [DIGIT_SEL_BITS-1:0] k_ff, k_in;
   logic [MUL_A_BITS-1:0]     a_ff, a_in;
   logic [MUL_B_BITS-1:0]     b_ff, b_in;
   logic                      neg_ff, neg_in;
   logic [PP_BITS-1:0]        pp_ff, pp_in;
   logic [MUL_ACC_BITS-1:0]   acc_ff, acc_in;
   logic [TERM_BITS-1:0]      term_ff, term_in;

   logic [SHIFTED_BITS-1:0]   shifted;
   logic [TERM_LIMIT_BIT:0]   mag;

   always_comb begin
      busy_in      = busy_ff;
      acc_phase_in = acc_phase_ff;
      fin_in       = 1'b0;
      k_in         = k_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      neg_in       = neg_ff;
      pp_in        = pp_ff;
      acc_in       = acc_ff;
      if (req.start) begin
         busy_in      = 1'b1;
         acc_phase_in = 1'b0;
         k_in         = '0;
         a_in         = req.a;
         b_in         = req.b;
         neg_in       = req.neg;
         acc_in       = '0;
      end else if (busy_ff) begin
         if (!acc_phase_ff) begin
            pp_in        = a_ff * b_ff[k_ff*DIGIT_BITS +: DIGIT_BITS];
            acc_phase_in = 1'b1;
         end else begin
            acc_in       = acc_ff + (MUL_ACC_BITS'(pp_ff) << (k_ff * DIGIT_BITS));
            acc_phase_in = 1'b0;
            if (k_ff == DIGIT_SEL_BITS'(DIGITS - 1)) begin
               busy_in = 1'b0;
               fin_in  = 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
      end
   end

   // drop the fraction bits, clamp to the term limit, then apply the sign
   always_comb begin
      shifted = acc_ff[MUL_ACC_BITS-1:FRAC_BITS];
      if (shifted > (SHIFTED_BITS'(1) << TERM_LIMIT_BIT))
         mag = (TERM_LIMIT_BIT+1)'(1) << TERM_LIMIT_BIT;
      else
         mag = shifted[TERM_LIMIT_BIT:0];
      term_in = neg_ff ? TERM_BITS'(-TERM_BITS'(mag)) : TERM_BITS'(mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         acc_phase_ff <= 1'b0;
         fin_ff       <= 1'b0;
         done_ff      <= 1'b0;
         k_ff         <= '0;
      end else begin
         busy_ff      <= busy_in;
         acc_phase_ff <= acc_phase_in;
         fin_ff       <= fin_in;
         done_ff      <= fin_ff;
         k_ff         <= k_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      neg_ff <= neg_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
      if (fin_ff) begin
         term_ff <= term_in;
      end
   end

   assign done = done_ff;
   assign term = term_ff;

endmodule

>>> rtl/pid_length_activation_controller_top.sv
// Top level of the PID length controller: sequencer, controller state and ports.
//
// Usage: each req beat carries a Q16.16 length-ratio setpoint, a measured
// length and a step time. The block answers every req beat with exactly one
// rsp beat holding the clamped activation (Q1.16, 0..1.0) and the saturated
// PID sum. Gains and the nominal length are written on the csr port while
// no beat is in flight.
// Flow: one beat at a time. req_stall is high from the accept until the
// result is loaded into the rsp register, and it drops in the same cycle as
// rsp_valid rises, so the next req beat can be taken while that result shows.
// A beat runs a bit-serial division of 49 quotient bits for the position and
// one for the derivative, which is skipped on the first step, after a setpoint
// change, on an unchanged error and on a zero step time; besides these it runs
// four passes of the shared digit-serial multiplier and three further states
// (S_ERR, S_DIFF, S_OUT).
// The next beat is accepted while a finished result waits on rsp_stall; that
// beat then holds in its last step until the rsp register frees up.
// Reset clears the controller state (setpoint, integral, last error, last
// activation), sets gains to zero and the nominal length to 1.0.
module pid_length_activation_controller_top import plac_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_target_ratio,
   input  logic [31:0]        req_measured_length,
   input  logic [31:0]        req_step_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [16:0]        rsp_activation,
   output logic signed [31:0] rsp_pid_sum,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_POS  = 4'd1;
   localparam logic [3:0] S_ERR  = 4'd2;
   localparam logic [3:0] S_MINT = 4'd3;
   localparam logic [3:0] S_DIFF = 4'd4;
   localparam logic [3:0] S_DDIV = 4'd5;
   localparam logic [3:0] S_MP   = 4'd6;
   localparam logic [3:0] S_MI   = 4'd7;
   localparam logic [3:0] S_MD   = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0]                state_ff, state_in;
   logic [31:0]               gain_p_ff, gain_p_in;
   logic [31:0]               gain_i_ff, gain_i_in;
   logic [31:0]               gain_d_ff, gain_d_in;
   logic [31:0]               nominal_ff, nominal_in;
   logic [31:0]               held_ff, held_in;
   logic [32:0]               last_err_ff, last_err_in;
   logic                      last_err_valid_ff, last_err_valid_in;
   logic [INTEGRAL_WIDTH-1:0] integral_ff, integral_in;
   logic [16:0]               last_act_ff, last_act_in;
   logic [31:0]               dt_ff, dt_in;
   logic [32:0]               err_ff, err_in;
   logic [DIV_BITS-1:0]       deriv_mag_ff, deriv_mag_in;
   logic                      deriv_neg_ff, deriv_neg_in;
   logic [TERM_BITS-1:0]      sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [16:0]               rsp_act_ff, rsp_act_in;
   logic [31:0]               rsp_sum_ff, rsp_sum_in;
   plac_div_req_type          div_req_ff, div_req_in;
   plac_mul_req_type          mul_req_ff, mul_req_in;

   logic                      div_done;
   logic [DIV_BITS-1:0]       div_quot;
   logic                      mul_done;
   logic [TERM_BITS-1:0]      mul_term;

   logic [31:0]               pos;
   logic [33:0]               err_wide;
   logic [32:0]               err_sat;
   logic [32:0]               err_mag;
   logic [31:0]               gain_p_mag, gain_i_mag, gain_d_mag;
   logic [INTEGRAL_WIDTH-1:0] integral_mag;
   logic [INTEGRAL_WIDTH+1:0] integral_sum;
   logic [INTEGRAL_WIDTH-1:0] integral_sat;
   logic [33:0]               diff;
   logic [32:0]               diff_mag;
   logic [31:0]               sum_sat;
   logic [33:0]               act_wide;
   logic [16:0]               act;
   logic                      accept;

   plac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   plac_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req_ff),
      .done  (mul_done),
      .term  (mul_term)
   );

   assign accept = req_valid && !req_stall;

   // datapath pieces around the shared units
   always_comb begin
      pos      = (div_quot[DIV_BITS-1:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
      err_wide = {{2{held_ff[31]}}, held_ff} - {2'b00, pos};
      // error floors at -2^32; it cannot exceed the top of its range
      err_sat  = (err_wide[33] && !err_wide[32]) ? 33'h1_0000_0000 : err_wide[32:0];
      err_mag  = err_ff[32] ? 33'(-err_ff) : err_ff;

      gain_p_mag   = gain_p_ff[31] ? 32'(-gain_p_ff) : gain_p_ff;
      gain_i_mag   = gain_i_ff[31] ? 32'(-gain_i_ff) : gain_i_ff;
      gain_d_mag   = gain_d_ff[31] ? 32'(-gain_d_ff) : gain_d_ff;
      integral_mag = integral_ff[INTEGRAL_WIDTH-1] ?
                     INTEGRAL_WIDTH'(-integral_ff) : integral_ff;

      integral_sum = {{2{integral_ff[INTEGRAL_WIDTH-1]}}, integral_ff}
                   + mul_term[INTEGRAL_WIDTH+1:0];
      if (integral_sum[INTEGRAL_WIDTH+1:INTEGRAL_WIDTH-1] == '0 ||
          integral_sum[INTEGRAL_WIDTH+1:INTEGRAL_WIDTH-1] == '1)
         integral_sat = integral_sum[INTEGRAL_WIDTH-1:0];
      else if (integral_sum[INTEGRAL_WIDTH+1])
         integral_sat = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
      else
         integral_sat = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};

      diff     = last_err_valid_ff ? ({err_ff[32], err_ff} - {last_err_ff[32], last_err_ff})
                                   : 34'd0;
      diff_mag = diff[33] ? 33'(-diff) : diff[32:0];

      if (sum_ff[TERM_BITS-1:31] == '0 || sum_ff[TERM_BITS-1:31] == '1)
         sum_sat = sum_ff[31:0];
      else if (sum_ff[TERM_BITS-1])
         sum_sat = 32'h8000_0000;
      else
         sum_sat = 32'h7FFF_FFFF;

      act_wide = {17'd0, last_act_ff} - {{2{sum_sat[31]}}, sum_sat};
      if (act_wide[33] || act_wide == '0)
         act = '0;
      else if (act_wide[32:16] != '0)
         act = ACT_ONE;
      else
         act = {1'b0, act_wide[15:0]};
   end

   always_comb begin
      state_in          = state_ff;
      gain_p_in         = gain_p_ff;
      gain_i_in         = gain_i_ff;
      gain_d_in         = gain_d_ff;
      nominal_in        = nominal_ff;
      held_in           = held_ff;
      last_err_in       = last_err_ff;
      last_err_valid_in = last_err_valid_ff;
      integral_in       = integral_ff;
      last_act_in       = last_act_ff;
      dt_in             = dt_ff;
      err_in            = err_ff;
      deriv_mag_in      = deriv_mag_ff;
      deriv_neg_in      = deriv_neg_ff;
      sum_in            = sum_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_act_in        = rsp_act_ff;
      rsp_sum_in        = rsp_sum_ff;
      div_req_in        = div_req_ff;
      div_req_in.start  = 1'b0;
      mul_req_in        = mul_req_ff;
      mul_req_in.start  = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN_P:         gain_p_in  = csr_wr_data;
            CSR_GAIN_I:         gain_i_in  = csr_wr_data;
            CSR_GAIN_D:         gain_d_in  = csr_wr_data;
            CSR_NOMINAL_LENGTH: nominal_in = csr_wr_data;
            default:            nominal_in = nominal_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // a new setpoint restarts the integral and the derivative history
               if (req_target_ratio != held_ff) begin
                  held_in           = req_target_ratio;
                  last_err_valid_in = 1'b0;
                  integral_in       = '0;
               end
               dt_in               = req_step_time;
               div_req_in.start    = 1'b1;
               div_req_in.dividend = DIV_BITS'({req_measured_length, {FRAC_BITS{1'b0}}});
               div_req_in.divisor  = nominal_ff;
               state_in            = S_POS;
            end
         end
         S_POS: begin
            if (div_done) begin
               err_in   = err_sat;
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            mul_req_in.start = 1'b1;
            mul_req_in.a     = err_mag;
            mul_req_in.b     = MUL_B_BITS'(dt_ff);
            mul_req_in.neg   = err_ff[32];
            state_in         = S_MINT;
         end
         S_MINT: begin
            if (mul_done) begin
               integral_in = integral_sat;
               state_in    = S_DIFF;
            end
         end
         S_DIFF: begin
            last_err_in       = err_ff;
            last_err_valid_in = 1'b1;
            deriv_neg_in      = diff[33];
            if (dt_ff == '0 || diff == '0) begin
               deriv_mag_in     = '0;
               mul_req_in.start = 1'b1;
               mul_req_in.a     = err_mag;
               mul_req_in.b     = MUL_B_BITS'(gain_p_mag);
               mul_req_in.neg   = gain_p_ff[31] ^ err_ff[32];
               state_in         = S_MP;
            end else begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = {diff_mag, {FRAC_BITS{1'b0}}};
               div_req_in.divisor  = dt_ff;
               state_in            = S_DDIV;
            end
         end
         S_DDIV: begin
            if (div_done) begin
               deriv_mag_in     = div_quot;
               mul_req_in.start = 1'b1;
               mul_req_in.a     = err_mag;
               mul_req_in.b     = MUL_B_BITS'(gain_p_mag);
               mul_req_in.neg   = gain_p_ff[31] ^ err_ff[32];
               state_in         = S_MP;
            end
         end
         S_MP: begin
            if (mul_done) begin
               sum_in           = mul_term;
               mul_req_in.start = 1'b1;
               mul_req_in.a     = MUL_A_BITS'(gain_i_mag);
               mul_req_in.b     = MUL_B_BITS'(integral_mag);
               mul_req_in.neg   = gain_i_ff[31] ^ integral_ff[INTEGRAL_WIDTH-1];
               state_in         = S_MI;
            end
         end
         S_MI: begin
            if (mul_done) begin
               sum_in           = sum_ff + mul_term;
               mul_req_in.start = 1'b1;
               mul_req_in.a     = MUL_A_BITS'(gain_d_mag);
               mul_req_in.b     = MUL_B_BITS'(deriv_mag_ff);
               mul_req_in.neg   = gain_d_ff[31] ^ deriv_neg_ff;
               state_in         = S_MD;
            end
         end
         S_MD: begin
            if (mul_done) begin
               sum_in   = sum_ff + mul_term;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the rsp register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = act;
               rsp_sum_in   = sum_sat;
               last_act_in  = act;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         nominal_ff        <= NOMINAL_RESET;
         held_ff           <= '0;
         last_err_ff       <= '0;
         last_err_valid_ff <= 1'b0;
         integral_ff       <= '0;
         last_act_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
         div_req_ff.start  <= 1'b0;
         mul_req_ff.start  <= 1'b0;
      end else begin
         state_ff          <= state_in;
         gain_p_ff         <= gain_p_in;
         gain_i_ff         <= gain_i_in;
         gain_d_ff         <= gain_d_in;
         nominal_ff        <= nominal_in;
         held_ff           <= held_in;
         last_err_ff       <= last_err_in;
         last_err_valid_ff <= last_err_valid_in;
         integral_ff       <= integral_in;
         last_act_ff       <= last_act_in;
         rsp_valid_ff      <= rsp_valid_in;
         div_req_ff.start  <= div_req_in.start;
         mul_req_ff.start  <= mul_req_in.start;
      end
      dt_ff               <= dt_in;
      err_ff              <= err_in;
      deriv_mag_ff        <= deriv_mag_in;
      deriv_neg_ff        <= deriv_neg_in;
      sum_ff              <= sum_in;
      rsp_act_ff          <= rsp_act_in;
      rsp_sum_ff          <= rsp_sum_in;
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
      mul_req_ff.a        <= mul_req_in.a;
      mul_req_ff.b        <= mul_req_in.b;
      mul_req_ff.neg      <= mul_req_in.neg;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_activation = rsp_act_ff;
   assign rsp_pid_sum    = rsp_sum_ff;

endmodule

>>> rtl/plac_checker.sv
// Port-level checks for the PID length controller, bound to the top level.
module plac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_activation,
   input logic [31:0] rsp_pid_sum
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_activation) && $stable(rsp_pid_sum))
      else $error("rsp beat changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_activation <= 17'h10000)
      else $error("activation above 1.0");

   // one beat in flight: the input side closes right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second req beat taken while busy");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the handshake state");

endmodule

bind pid_length_activation_controller_top plac_checker u_plac_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_activation (rsp_activation),
   .rsp_pid_sum    (rsp_pid_sum)
);

>>> tb/tb_pid_length_activation_controller_top.sv
// Self-checking testbench for the PID length controller: directed corners, backpressure, random phases.
module tb_pid_length_activation_controller_top import plac_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     LONG_HOLD_CYCLES = 600;
   localparam int     DRAIN_LIMIT      = 5000;
   localparam int     TAIL_CYCLES      = 150;
   localparam longint TERM_MAX   = longint'(1) << TERM_LIMIT_BIT;
   localparam longint INTEG_MAX  = (longint'(1) << (INTEGRAL_WIDTH - 1)) - 1;
   localparam longint INTEG_MIN  = -INTEG_MAX - 1;
   localparam longint ERR_MAX    = 64'sh0000_0000_FFFF_FFFF;
   localparam longint ERR_MIN    = -ERR_MAX - 1;
   localparam longint SUM_MAX    = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SUM_MIN    = -SUM_MAX - 1;
   localparam longint ACT_SCALE  = longint'(1) << FRAC_BITS;
   localparam longint ACT_FULL   = longint'(1) << (FRAC_BITS + 16);

   typedef struct {
      logic [16:0]        activation;
      logic signed [31:0] pid_sum;
   } ctl_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_target_ratio = '0;
   logic [31:0]        req_measured_length = '0;
   logic [31:0]        req_step_time = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [16:0]        rsp_activation;
   logic signed [31:0] rsp_pid_sum;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wr_data = '0;

   // controller image: configuration and state
   logic signed [31:0] cfg_kp = '0;
   logic signed [31:0] cfg_ki = '0;
   logic signed [31:0] cfg_kd = '0;
   logic [31:0]        cfg_nominal = NOMINAL_RESET;
   logic [31:0]        ctl_setpoint = '0;
   longint             ctl_prev_err = 0;
   bit                 ctl_prev_ok = 1'b0;
   longint             ctl_integral = 0;
   logic [16:0]        ctl_activation = '0;

   ctl_result_type     pending_results[$];
   int                 mismatches = 0;
   bit                 req_idle_en = 1'b1;
   bit                 rsp_idle_en = 1'b1;
   int                 long_hold_req = 0;
   int                 long_hold_seen = 0;
   logic [31:0]        walk_target = 32'h0001_0000;

   pid_length_activation_controller_top dut (.*);

   always #1 clock = ~clock;

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // (a*b) >> FRAC_BITS on magnitudes, truncated toward zero, limited to +-2^61
   function automatic longint fx_mul(longint a, longint b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] prod;
      longint       r;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      prod = ({64'b0, ma} * {64'b0, mb}) >> FRAC_BITS;
      if (prod > TERM_MAX) r = TERM_MAX;
      else r = longint'(prod[63:0]);
      if ((a < 0) != (b < 0)) r = -r;
      return r;
   endfunction

   function automatic ctl_result_type predict_step(logic [31:0] target, logic [31:0] measured,
                                                   logic [31:0] dt);
      logic [63:0]    pos;
      logic [63:0]    mag;
      logic [63:0]    quo;
      longint         err;
      longint         diff;
      longint         deriv;
      longint         sum;
      longint         term;
      longint         act;
      ctl_result_type res;
      if (target != ctl_setpoint) begin
         ctl_setpoint = target;
         ctl_prev_ok = 1'b0;
         ctl_integral = 0;
      end
      if (cfg_nominal == 0) begin
         pos = 64'hFFFF_FFFF;
      end else begin
         pos = ({32'b0, measured} << FRAC_BITS) / {32'b0, cfg_nominal};
         if (pos > 64'hFFFF_FFFF) pos = 64'hFFFF_FFFF;
      end
      err = longint'($signed(target)) - longint'(pos);
      if (err > ERR_MAX) err = ERR_MAX;
      if (err < ERR_MIN) err = ERR_MIN;
      ctl_integral = ctl_integral + fx_mul(err, longint'({32'b0, dt}));
      if (ctl_integral > INTEG_MAX) ctl_integral = INTEG_MAX;
      if (ctl_integral < INTEG_MIN) ctl_integral = INTEG_MIN;
      diff = ctl_prev_ok ? err - ctl_prev_err : 0;
      if (dt == 0 || diff == 0) begin
         deriv = 0;
      end else begin
         mag = (diff < 0) ? -diff : diff;
         quo = (mag << FRAC_BITS) / {32'b0, dt};
         deriv = (diff < 0) ? -longint'(quo) : longint'(quo);
      end
      ctl_prev_err = err;
      ctl_prev_ok = 1'b1;
      sum = fx_mul(longint'(cfg_kp), err) + fx_mul(longint'(cfg_ki), ctl_integral)
          + fx_mul(longint'(cfg_kd), deriv);
      if (sum > SUM_MAX) sum = SUM_MAX;
      if (sum < SUM_MIN) sum = SUM_MIN;
      term = longint'(ctl_activation) * ACT_SCALE - sum * 65536;
      if (term <= 0) act = 0;
      else if (term >= ACT_FULL) act = 65536;
      else act = term >>> FRAC_BITS;
      ctl_activation = act[16:0];
      res.activation = act[16:0];
      res.pid_sum = sum[31:0];
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      ctl_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected beat act=%0d sum=%0d",
                                      rsp_activation, rsp_pid_sum));
         end else begin
            want = pending_results.pop_front();
            if (rsp_activation !== want.activation)
               report_mismatch($sformatf("activation got %0d want %0d",
                                         rsp_activation, want.activation));
            if (rsp_pid_sum !== want.pid_sum)
               report_mismatch($sformatf("pid_sum got %0d want %0d",
                                         rsp_pid_sum, want.pid_sum));
         end
      end
   end

   // result sink: random stall bursts and the requested long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req != long_hold_seen) begin
            long_hold_seen = long_hold_req;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_step(logic [31:0] target, logic [31:0] measured, logic [31:0] dt);
      if (req_idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_ratio <= target;
      req_measured_length <= measured;
      req_step_time <= dt;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_step(target, measured, dt));
   endtask

   // drop valid and hold until every beat has come back or DRAIN_LIMIT runs out
   task automatic wait_idle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_results.size() != 0 && guard < DRAIN_LIMIT);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_GAIN_P:         cfg_kp = data;
         CSR_GAIN_I:         cfg_ki = data;
         CSR_GAIN_D:         cfg_kd = data;
         CSR_NOMINAL_LENGTH: cfg_nominal = data;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                             logic [31:0] nominal);
      wait_idle();
      write_reg(CSR_GAIN_P, kp);
      write_reg(CSR_GAIN_I, ki);
      write_reg(CSR_GAIN_D, kd);
      write_reg(CSR_NOMINAL_LENGTH, nominal);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4, 5: return $urandom_range(0, 32'h0002_0000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      logic [31:0] g;
      if ($urandom_range(0, 3) == 0) return $urandom();
      g = $urandom_range(0, 32'h0002_0000);
      if ($urandom_range(0, 1) == 1) g = -g;
      return g;
   endfunction

   function automatic logic [31:0] pick_nominal();
      case ($urandom_range(0, 3))
         0: return $urandom_range(1, 32'hFFFF_FFFF);
         1: return 32'h0001_0000;
         default: return $urandom_range(32'h0000_1000, 32'h0004_0000);
      endcase
   endfunction

   // mostly a held setpoint with lengths near it, so integral and derivative build up
   task automatic run_random_steps(int count);
      logic [63:0] lin;
      logic [31:0] meas;
      logic [31:0] dt;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 12) begin
            if ($urandom_range(0, 3) != 0) walk_target = $urandom_range(0, 32'h0002_0000);
            else walk_target = pick_word();
         end
         if ($urandom_range(0, 9) < 7) begin
            lin = ({32'b0, walk_target} * {32'b0, cfg_nominal}) >> FRAC_BITS;
            lin = lin + $urandom_range(0, 32'h2000) - 32'h1000;
            meas = (lin > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lin[31:0];
         end else begin
            meas = pick_word();
         end
         case ($urandom_range(0, 19))
            0: dt = 32'h0;
            1, 2, 3, 4: dt = pick_word();
            default: dt = $urandom_range(1, 32'h0001_0000);
         endcase
         send_step(walk_target, meas, dt);
      end
   endtask

   task automatic test_reset_defaults();
      send_step(32'h0001_0000, 32'h0000_8000, 32'h0001_0000);
      send_step(32'h0001_0000, 32'h0002_0000, 32'h0000_4000);
      send_step(32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0);
   endtask

   task automatic test_directed_cases();
      set_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000);
      send_step(32'h0000_8000, 32'h0000_4000, 32'h0001_0000);   // first step
      send_step(32'h0000_8000, 32'h0000_6000, 32'h0001_0000);   // derivative active
      send_step(32'h0000_8000, 32'h0000_2000, 32'h0);           // zero step time
      send_step(32'h0000_8000, 32'h0000_2000, 32'h0000_8000);   // unchanged error
      send_step(32'hFFFF_0000, 32'h0000_8000, 32'h0000_8000);   // setpoint change, negative
      send_step(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_step(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // error clips low
      send_step(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001);
      send_step(32'h8000_0000, 32'h0000_0000, 32'h0000_0001);   // derivative huge
      // position saturates with a tiny nominal length; products and sum clip
      set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
      send_step(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_step(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_step(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001);
      send_step(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      send_step(32'h0000_0000, 32'h0000_1234, 32'h0001_0000);   // zero nominal length
      send_step(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
      set_config(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_step(32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_FFFF);
      send_step(32'h0001_0000, 32'h0000_0000, 32'h0000_0003);
      send_step(32'h0001_0000, 32'h7FFF_0000, 32'h0000_0003);
      set_config(32'h0000_4000, 32'h0000_1000, 32'h0000_0100, 32'h0001_0000);
      send_step(32'h0000_C000, 32'h0001_0000, 32'h0000_1000);   // rise toward full
      send_step(32'h0000_C000, 32'h0001_8000, 32'h0000_1000);
      send_step(32'h0000_C000, 32'h0000_0000, 32'h0000_1000);
   endtask

   task automatic test_backpressure();
      wait_idle();
      req_idle_en = 1'b0;
      long_hold_req <= long_hold_req + 1;
      repeat (8) send_step(walk_target, $urandom(), $urandom_range(0, 32'h0001_0000));
      req_idle_en = 1'b1;
   endtask

   task automatic test_pause_until_drained();
      repeat (5) send_step(walk_target, $urandom_range(0, 32'h0002_0000), $urandom());
      wait_idle();
      repeat (5) send_step(walk_target, $urandom_range(0, 32'h0002_0000), $urandom());
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_config(32'h0001_0000, 32'h0000_4000, 32'h0000_0400, 32'h0001_0000);
            1: set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
            2: set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
            default: set_config(pick_gain(), pick_gain(), pick_gain(), pick_nominal());
         endcase
         // last phase runs without gaps on either side
         if (ph == 7) begin
            req_idle_en = 1'b0;
            rsp_idle_en <= 1'b0;
         end
         run_random_steps(232);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_backpressure();
      test_pause_until_drained();
      test_random_phases();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d beats never returned", pending_results.size()));
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> pid_length_activation_controller_top.f
rtl/plac_pkg.sv
rtl/plac_div.sv
rtl/plac_mul.sv
rtl/pid_length_activation_controller_top.sv
rtl/plac_checker.sv
tb/tb_pid_length_activation_controller_top.sv
